// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cecs_pkg.sv =====
package cecs_pkg;

    localparam int MAX_CIRCLES = 64;
    localparam int AW          = $clog2(MAX_CIRCLES);
    localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);

    localparam int SLOT_W = 6;
    localparam int POS_W  = 20;
    localparam int VEL_W  = 21;
    localparam int RAD_W  = 16;
    localparam int MASS_W = 16;
    localparam int EXC_W  = 16;
    localparam int HW_W   = 19;
    localparam int T_W    = 16;
    localparam int CC_W   = 7;

    // v * t product, rounded time product, look-ahead position, difference
    localparam int PROD_W = VEL_W + T_W + 1;
    localparam int TM_W   = PROD_W - 16;
    localparam int LA_W   = TM_W + 1;
    localparam int DIFF_W = LA_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int RS_W   = RAD_W + 1;

    // divider operands: 2*num + den and 2*den
    localparam int NUM_W = 42;
    localparam int DEN_W = MASS_W + 2;

    localparam int PADDR_W = 5;
    localparam int DATA_W  = 32;

    localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_TIME_STEP    = 3'd2;
    localparam logic [2:0] REG_LOOKAHEAD    = 3'd3;
    localparam logic [2:0] REG_CIRCLE_COUNT = 3'd4;

    localparam logic [HW_W-1:0] HALF_WIDTH_RST  = 19'd163840;
    localparam logic [HW_W-1:0] HALF_HEIGHT_RST = 19'd76800;
    localparam logic [T_W-1:0]  TIME_STEP_RST   = 16'd262;
    localparam logic [T_W-1:0]  LOOKAHEAD_RST   = 16'd1311;
    localparam logic [CC_W-1:0] CIRCLE_CNT_RST  = 7'd0;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 21'sd1048575;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -21'sd1048576;
    localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
    localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;

    typedef struct packed {
        logic [HW_W-1:0] half_width;
        logic [HW_W-1:0] half_height;
        logic [T_W-1:0]  time_step;
        logic [T_W-1:0]  lookahead_time;
        logic [CC_W-1:0] circle_count;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [RAD_W-1:0]        radius;
        logic [MASS_W-1:0]       mass;
        logic [EXC_W-1:0]        exc;
    } circ_t;

    localparam int ENT_W = $bits(circ_t);

    function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
        if (v == VEL_MIN)
        begin
            return VEL_MAX;
        end
        return -v;
    endfunction

    function automatic logic [EXC_W-1:0] exc_add(input logic [EXC_W-1:0] e,
                                                 input logic [2:0] hits);
        logic [EXC_W+1:0] s;
        s = {2'b00, e} + {{(EXC_W-8){1'b0}}, hits, 7'd0};
        if (s > {2'b00, {EXC_W{1'b1}}})
        begin
            return {EXC_W{1'b1}};
        end
        return s[EXC_W-1:0];
    endfunction

    // floor((p + 32768) / 65536)
    function automatic logic signed [TM_W-1:0] tm_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(32768);
        return s[PROD_W-1:16];
    endfunction

    function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [LA_W-1:0] v);
        if (v > LA_W'(POS_MAX))
        begin
            return POS_MAX;
        end
        if (v < LA_W'(POS_MIN))
        begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== design/cecs_if.sv =====
interface cecs_item_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [cecs_pkg::SLOT_W-1:0]        slot;
    logic signed [cecs_pkg::POS_W-1:0]  load_pos_x;
    logic signed [cecs_pkg::POS_W-1:0]  load_pos_y;
    logic signed [cecs_pkg::VEL_W-1:0]  load_vel_x;
    logic signed [cecs_pkg::VEL_W-1:0]  load_vel_y;
    logic [cecs_pkg::RAD_W-1:0]         load_radius;
    logic [cecs_pkg::MASS_W-1:0]        load_mass;

    modport source (output valid, kind, slot, load_pos_x, load_pos_y, load_vel_x,
                    load_vel_y, load_radius, load_mass, input ready);
    modport sink (input valid, kind, slot, load_pos_x, load_pos_y, load_vel_x,
                  load_vel_y, load_radius, load_mass, output ready);
endinterface

interface cecs_result_if;
    logic                               valid;
    logic                               ready;
    logic [cecs_pkg::SLOT_W-1:0]        out_slot;
    logic signed [cecs_pkg::POS_W-1:0]  out_pos_x;
    logic signed [cecs_pkg::POS_W-1:0]  out_pos_y;
    logic signed [cecs_pkg::VEL_W-1:0]  out_vel_x;
    logic signed [cecs_pkg::VEL_W-1:0]  out_vel_y;
    logic [cecs_pkg::EXC_W-1:0]         out_excitement;
    logic                               last;

    modport source (output valid, out_slot, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    out_excitement, last, input ready);
    modport sink (input valid, out_slot, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  out_excitement, last, output ready);
endinterface

// ===== design/circle_elastic_collision_step.sv =====
// channel  dir  contents
// item     in   kind, slot, load position/velocity/radius/mass
// result   out  slot, position, velocity, excitement, last
// apb      in   five config registers at byte address 4*index
//
// Load: written straight into the circle RAM.
// Step: each circle is read, bounced off the walls and moved; then each pair is
// read, looked ahead and compared, and a colliding pair with nonzero total mass
// takes four passes of the shared divider; then each circle is reported. The single RAM write port sets the pace.
// Reset clears control only; the circle RAM holds garbage until loaded.
// A stalled result holds in the output register; later results wait for it.
`include "assert_macros.svh"

module circle_elastic_collision_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cecs_pkg::PADDR_W-1:0]   paddr,
    input  logic [cecs_pkg::DATA_W-1:0]    pwdata,
    output logic [cecs_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    cecs_item_if.sink                      item,
    cecs_result_if.source                  result
);

    localparam int AW  = cecs_pkg::AW;
    localparam int CW  = cecs_pkg::CNT_W;
    localparam int CW1 = cecs_pkg::CNT_W + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_W_RD  = 5'd1;
    localparam logic [4:0] S_W_A   = 5'd2;
    localparam logic [4:0] S_W_B   = 5'd3;
    localparam logic [4:0] S_W_C   = 5'd4;
    localparam logic [4:0] S_P_RD  = 5'd5;
    localparam logic [4:0] S_P_LA  = 5'd6;
    localparam logic [4:0] S_P_SQ  = 5'd7;
    localparam logic [4:0] S_P_MUL = 5'd8;
    localparam logic [4:0] S_P_CMP = 5'd9;
    localparam logic [4:0] S_X_NUM = 5'd10;
    localparam logic [4:0] S_X_DIV = 5'd11;
    localparam logic [4:0] S_X_WT  = 5'd12;
    localparam logic [4:0] S_X_WRI = 5'd13;
    localparam logic [4:0] S_X_WRJ = 5'd14;
    localparam logic [4:0] S_P_NXT = 5'd15;
    localparam logic [4:0] S_O_RD  = 5'd16;
    localparam logic [4:0] S_O_LD  = 5'd17;

    cecs_pkg::cfg_t cfg;

    logic [4:0]     state_reg;
    logic [CW-1:0]  i_reg;
    logic [CW-1:0]  j_reg;
    logic [CW-1:0]  n_reg;
    logic [1:0]     k_reg;
    logic           out_valid_reg;

    cecs_pkg::circ_t cur_reg;
    cecs_pkg::circ_t oth_reg;
    cecs_pkg::circ_t rd_a;
    cecs_pkg::circ_t rd_b;
    cecs_pkg::circ_t wdata;
    logic            ram_we;
    logic [AW-1:0]   waddr;

    logic signed [cecs_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [cecs_pkg::DIFF_W-1:0] dx_reg;
    logic signed [cecs_pkg::DIFF_W-1:0] dy_reg;
    logic [cecs_pkg::RS_W-1:0]          rs_reg;
    logic signed [cecs_pkg::SQ_W-1:0]   dx2_reg;
    logic signed [cecs_pkg::SQ_W-1:0]   dy2_reg;
    logic [2*cecs_pkg::RS_W-1:0]        rs2_reg;
    logic signed [cecs_pkg::VEL_W-1:0]  res_reg [4];
    logic signed [cecs_pkg::NUM_W-1:0]  div_num_reg;
    logic [cecs_pkg::DEN_W-1:0]         div_den_reg;

    logic [cecs_pkg::SLOT_W-1:0]        o_slot_reg;
    logic signed [cecs_pkg::POS_W-1:0]  o_px_reg;
    logic signed [cecs_pkg::POS_W-1:0]  o_py_reg;
    logic signed [cecs_pkg::VEL_W-1:0]  o_vx_reg;
    logic signed [cecs_pkg::VEL_W-1:0]  o_vy_reg;
    logic [cecs_pkg::EXC_W-1:0]         o_exc_reg;
    logic                               o_last_reg;

    logic                               div_start;
    logic                               div_busy;
    logic                               div_done;
    logic signed [cecs_pkg::VEL_W-1:0]  div_quo;

    logic [CW-1:0]                      n_cfg;
    logic                               load_go;
    logic                               step_go;
    logic                               out_free;
    logic                               hit;
    logic [cecs_pkg::MASS_W:0]          den;

    // wall stage
    logic signed [21:0] wx, wy, wr, whw, whh;
    logic               c1, c2, c3, c4;
    logic signed [cecs_pkg::VEL_W-1:0] vx1, vx2, vy1, vy2;

    // exchange operand select
    logic signed [cecs_pkg::MASS_W:0]   mi, mo;
    logic signed [cecs_pkg::VEL_W-1:0]  vi, vo;
    logic signed [cecs_pkg::PROD_W-1:0] p1, p2;
    logic signed [cecs_pkg::NUM_W-1:0]  nsum;

    logic signed [cecs_pkg::LA_W-1:0]   lxi, lyi, lxj, lyj;
    logic [cecs_pkg::SQ_W:0]            dsum;

    cecs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cecs_ram #(
        .W     (cecs_pkg::ENT_W),
        .DEPTH (cecs_pkg::MAX_CIRCLES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_reg[AW-1:0]),
        .rdata_a (rd_a),
        .raddr_b (j_reg[AW-1:0]),
        .rdata_b (rd_b)
    );

    cecs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign n_cfg = (cfg.circle_count > cecs_pkg::CC_W'(cecs_pkg::MAX_CIRCLES))
                 ? CW'(cecs_pkg::MAX_CIRCLES) : cfg.circle_count[CW-1:0];

    assign item.ready = (state_reg == S_IDLE);
    assign load_go    = item.valid && item.ready && !item.kind
                     && (int'(item.slot) < cecs_pkg::MAX_CIRCLES);
    assign step_go    = item.valid && item.ready && item.kind;
    assign out_free   = !out_valid_reg || result.ready;
    assign div_start  = (state_reg == S_X_DIV);

    // walls: a circle can touch both walls of an axis, so negate twice
    assign wx  = 22'(rd_a.pos_x);
    assign wy  = 22'(rd_a.pos_y);
    assign wr  = 22'(rd_a.radius);
    assign whw = 22'(cfg.half_width);
    assign whh = 22'(cfg.half_height);
    assign c1  = (wx + wr) > whw;
    assign c2  = (wx - wr) < -whw;
    assign c3  = (wy + wr) > whh;
    assign c4  = (wy - wr) < -whh;
    assign vx1 = c1 ? cecs_pkg::neg_sat(rd_a.vel_x) : rd_a.vel_x;
    assign vx2 = c2 ? cecs_pkg::neg_sat(vx1) : vx1;
    assign vy1 = c3 ? cecs_pkg::neg_sat(rd_a.vel_y) : rd_a.vel_y;
    assign vy2 = c4 ? cecs_pkg::neg_sat(vy1) : vy1;

    assign lxi = LA_W_EXT(cur_reg.pos_x) + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[0]));
    assign lyi = LA_W_EXT(cur_reg.pos_y) + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[1]));
    assign lxj = LA_W_EXT(oth_reg.pos_x) + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[2]));
    assign lyj = LA_W_EXT(oth_reg.pos_y) + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[3]));

    function automatic logic signed [cecs_pkg::LA_W-1:0] LA_W_EXT(
        input logic signed [cecs_pkg::POS_W-1:0] p);
        return cecs_pkg::LA_W'(p);
    endfunction

    assign dsum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit  = dsum < (cecs_pkg::SQ_W + 1)'(rs2_reg);
    assign den  = {1'b0, cur_reg.mass} + {1'b0, oth_reg.mass};

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                mi = $signed({1'b0, cur_reg.mass}); mo = $signed({1'b0, oth_reg.mass});
                vi = cur_reg.vel_x; vo = oth_reg.vel_x;
            end
            2'd1:
            begin
                mi = $signed({1'b0, cur_reg.mass}); mo = $signed({1'b0, oth_reg.mass});
                vi = cur_reg.vel_y; vo = oth_reg.vel_y;
            end
            2'd2:
            begin
                mi = $signed({1'b0, oth_reg.mass}); mo = $signed({1'b0, cur_reg.mass});
                vi = oth_reg.vel_x; vo = cur_reg.vel_x;
            end
            default:
            begin
                mi = $signed({1'b0, oth_reg.mass}); mo = $signed({1'b0, cur_reg.mass});
                vi = oth_reg.vel_y; vo = cur_reg.vel_y;
            end
        endcase
    end

    assign p1   = mo * vo;
    assign p2   = (mi - mo) * vi;
    // 2*(2*mo*vo + (mi-mo)*vi) + den, for rounding to nearest
    assign nsum = (cecs_pkg::NUM_W'(p1) <<< 2) + (cecs_pkg::NUM_W'(p2) <<< 1)
                + cecs_pkg::NUM_W'($signed({1'b0, den}));

    always_comb
    begin
        ram_we = 1'b0;
        waddr  = i_reg[AW-1:0];
        wdata  = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                ram_we       = load_go;
                waddr        = item.slot[AW-1:0];
                wdata.pos_x  = item.load_pos_x;
                wdata.pos_y  = item.load_pos_y;
                wdata.vel_x  = item.load_vel_x;
                wdata.vel_y  = item.load_vel_y;
                wdata.radius = item.load_radius;
                wdata.mass   = item.load_mass;
                wdata.exc    = '0;
            end
            S_W_C:
            begin
                ram_we      = 1'b1;
                wdata.pos_x = cecs_pkg::pos_sat(LA_W_EXT(cur_reg.pos_x)
                              + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[0])));
                wdata.pos_y = cecs_pkg::pos_sat(LA_W_EXT(cur_reg.pos_y)
                              + cecs_pkg::LA_W'(cecs_pkg::tm_round(prod_reg[1])));
            end
            S_X_WRI:
            begin
                ram_we      = 1'b1;
                wdata.vel_x = res_reg[0];
                wdata.vel_y = res_reg[1];
                wdata.exc   = cecs_pkg::exc_add(cur_reg.exc, 3'd1);
            end
            S_X_WRJ:
            begin
                ram_we      = 1'b1;
                waddr       = j_reg[AW-1:0];
                wdata       = oth_reg;
                wdata.vel_x = res_reg[2];
                wdata.vel_y = res_reg[3];
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (step_go && (n_cfg != '0))
                    begin
                        n_reg     <= n_cfg;
                        i_reg     <= '0;
                        state_reg <= S_W_RD;
                    end
                end
                S_W_RD:  state_reg <= S_W_A;
                S_W_A:   state_reg <= S_W_B;
                S_W_B:   state_reg <= S_W_C;
                S_W_C:
                begin
                    if (i_reg + 1'b1 < n_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_W_RD;
                    end
                    else if (n_reg >= CW'(2))
                    begin
                        i_reg     <= '0;
                        j_reg     <= CW'(1);
                        state_reg <= S_P_RD;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_O_RD;
                    end
                end
                S_P_RD:  state_reg <= S_P_LA;
                S_P_LA:  state_reg <= S_P_SQ;
                S_P_SQ:  state_reg <= S_P_MUL;
                S_P_MUL: state_reg <= S_P_CMP;
                S_P_CMP:
                begin
                    k_reg <= '0;
                    if (!hit)
                    begin
                        state_reg <= S_P_NXT;
                    end
                    else if (den == '0)
                    begin
                        state_reg <= S_X_WRI;
                    end
                    else
                    begin
                        state_reg <= S_X_NUM;
                    end
                end
                S_X_NUM: state_reg <= S_X_DIV;
                S_X_DIV: state_reg <= S_X_WT;
                S_X_WT:
                begin
                    if (div_done)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == 2'd3) ? S_X_WRI : S_X_NUM;
                    end
                end
                S_X_WRI: state_reg <= S_X_WRJ;
                S_X_WRJ: state_reg <= S_P_NXT;
                S_P_NXT:
                begin
                    if (j_reg + 1'b1 < n_reg)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_P_RD;
                    end
                    else if (CW1'(i_reg) + CW1'(2) < CW1'(n_reg))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= i_reg + CW'(2);
                        state_reg <= S_P_RD;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_O_RD;
                    end
                end
                S_O_RD:  state_reg <= S_O_LD;
                S_O_LD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (i_reg + 1'b1 < n_reg)
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_O_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_W_A:
            begin
                cur_reg       <= rd_a;
                cur_reg.vel_x <= vx2;
                cur_reg.vel_y <= vy2;
                cur_reg.exc   <= cecs_pkg::exc_add(rd_a.exc, 3'(c1) + 3'(c2) + 3'(c3) + 3'(c4));
            end
            S_W_B:
            begin
                prod_reg[0] <= cur_reg.vel_x * $signed({1'b0, cfg.time_step});
                prod_reg[1] <= cur_reg.vel_y * $signed({1'b0, cfg.time_step});
            end
            S_P_LA:
            begin
                cur_reg     <= rd_a;
                oth_reg     <= rd_b;
                prod_reg[0] <= rd_a.vel_x * $signed({1'b0, cfg.lookahead_time});
                prod_reg[1] <= rd_a.vel_y * $signed({1'b0, cfg.lookahead_time});
                prod_reg[2] <= rd_b.vel_x * $signed({1'b0, cfg.lookahead_time});
                prod_reg[3] <= rd_b.vel_y * $signed({1'b0, cfg.lookahead_time});
            end
            S_P_SQ:
            begin
                dx_reg <= cecs_pkg::DIFF_W'(lxi) - cecs_pkg::DIFF_W'(lxj);
                dy_reg <= cecs_pkg::DIFF_W'(lyi) - cecs_pkg::DIFF_W'(lyj);
                rs_reg <= {1'b0, cur_reg.radius} + {1'b0, oth_reg.radius};
            end
            S_P_MUL:
            begin
                dx2_reg <= dx_reg * dx_reg;
                dy2_reg <= dy_reg * dy_reg;
                rs2_reg <= rs_reg * rs_reg;
            end
            S_P_CMP:
            begin
                res_reg[0]  <= cur_reg.vel_x;
                res_reg[1]  <= cur_reg.vel_y;
                res_reg[2]  <= oth_reg.vel_x;
                res_reg[3]  <= oth_reg.vel_y;
                div_den_reg <= {den, 1'b0};
            end
            S_X_NUM:
            begin
                div_num_reg <= nsum;
            end
            S_X_WT:
            begin
                if (div_done)
                begin
                    res_reg[k_reg] <= div_quo;
                end
            end
            S_O_LD:
            begin
                if (out_free)
                begin
                    o_slot_reg <= cecs_pkg::SLOT_W'(i_reg[AW-1:0]);
                    o_px_reg   <= rd_a.pos_x;
                    o_py_reg   <= rd_a.pos_y;
                    o_vx_reg   <= rd_a.vel_x;
                    o_vy_reg   <= rd_a.vel_y;
                    o_exc_reg  <= rd_a.exc;
                    o_last_reg <= (i_reg + 1'b1 == n_reg);
                end
            end
            default: ;
        endcase
    end

    assign result.valid          = out_valid_reg;
    assign result.out_slot       = o_slot_reg;
    assign result.out_pos_x      = o_px_reg;
    assign result.out_pos_y      = o_py_reg;
    assign result.out_vel_x      = o_vx_reg;
    assign result.out_vel_y      = o_vy_reg;
    assign result.out_excitement = o_exc_reg;
    assign result.last           = o_last_reg;

    `ASSERT_IMPL(a_no_write_in_div, div_busy, !ram_we, "RAM written while divider busy")
    `ASSERT_IMPL(a_done_in_wait, div_done, state_reg == S_X_WT, "divider done outside wait")
    `ASSERT_NEXT(a_j_after_i, state_reg == S_X_WRI, state_reg == S_X_WRJ,
                 "second circle not written after first")

endmodule

// ===== design/cecs_ram.sv =====
module cecs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [W-1:0]             rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [W-1:0]             rdata_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/cecs_regs.sv =====
module cecs_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cecs_pkg::PADDR_W-1:0]   paddr,
    input  logic [cecs_pkg::DATA_W-1:0]    pwdata,
    output logic [cecs_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output cecs_pkg::cfg_t                 cfg
);

    cecs_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;

    assign idx    = paddr[cecs_pkg::PADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_width     <= cecs_pkg::HALF_WIDTH_RST;
            cfg_reg.half_height    <= cecs_pkg::HALF_HEIGHT_RST;
            cfg_reg.time_step      <= cecs_pkg::TIME_STEP_RST;
            cfg_reg.lookahead_time <= cecs_pkg::LOOKAHEAD_RST;
            cfg_reg.circle_count   <= cecs_pkg::CIRCLE_CNT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                cecs_pkg::REG_HALF_WIDTH:
                    cfg_reg.half_width <= pwdata[cecs_pkg::HW_W-1:0];
                cecs_pkg::REG_HALF_HEIGHT:
                    cfg_reg.half_height <= pwdata[cecs_pkg::HW_W-1:0];
                cecs_pkg::REG_TIME_STEP:
                    cfg_reg.time_step <= pwdata[cecs_pkg::T_W-1:0];
                cecs_pkg::REG_LOOKAHEAD:
                    cfg_reg.lookahead_time <= pwdata[cecs_pkg::T_W-1:0];
                cecs_pkg::REG_CIRCLE_COUNT:
                    cfg_reg.circle_count <= pwdata[cecs_pkg::CC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cecs_pkg::REG_HALF_WIDTH:
                prdata = cecs_pkg::DATA_W'(cfg_reg.half_width);
            cecs_pkg::REG_HALF_HEIGHT:
                prdata = cecs_pkg::DATA_W'(cfg_reg.half_height);
            cecs_pkg::REG_TIME_STEP:
                prdata = cecs_pkg::DATA_W'(cfg_reg.time_step);
            cecs_pkg::REG_LOOKAHEAD:
                prdata = cecs_pkg::DATA_W'(cfg_reg.lookahead_time);
            cecs_pkg::REG_CIRCLE_COUNT:
                prdata = cecs_pkg::DATA_W'(cfg_reg.circle_count);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== design/cecs_div.sv =====
// Restoring divider, one quotient bit a cycle. Floor quotient of a signed
// numerator by a positive divisor, saturated to the velocity range.
module cecs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [cecs_pkg::NUM_W-1:0]   num,
    input  logic [cecs_pkg::DEN_W-1:0]          den,
    output logic                                busy,
    output logic                                done,
    output logic signed [cecs_pkg::VEL_W-1:0]   quo
);

    localparam int MAG_W = cecs_pkg::NUM_W - 1;
    localparam int CW    = $clog2(MAG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [MAG_W-1:0] mq_reg;
    logic [cecs_pkg::DEN_W-1:0] rem_reg;
    logic             neg_reg;

    logic [cecs_pkg::DEN_W:0]   rem_sh;
    logic                       ge;
    logic [cecs_pkg::DEN_W:0]   rem_sub;
    logic                       big;

    assign rem_sh  = {rem_reg, mq_reg[MAG_W-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign rem_sub = rem_sh - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // negative numerator divides ~num = |num|-1, answer is then ~q
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[cecs_pkg::NUM_W-1];
            mq_reg  <= num[cecs_pkg::NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[cecs_pkg::DEN_W-1:0] : rem_sh[cecs_pkg::DEN_W-1:0];
            mq_reg  <= {mq_reg[MAG_W-2:0], ge};
        end
    end

    assign big = |mq_reg[MAG_W-1:cecs_pkg::VEL_W-1];

    always_comb
    begin
        if (neg_reg)
        begin
            quo = big ? cecs_pkg::VEL_MIN : ~mq_reg[cecs_pkg::VEL_W-1:0];
        end
        else
        begin
            quo = big ? cecs_pkg::VEL_MAX : mq_reg[cecs_pkg::VEL_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
